[hdl/llag_pkg.sv]
// shared types, codes and constants of the life-like automaton grid
`default_nettype none

package llag_pkg;

    // default store size
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;

    // field and port widths
    localparam int COUNT_W     = 7;
    localparam int MASK_W      = 9;
    localparam int MODE_W      = 2;
    localparam int COORD_W     = 6;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 9;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 8;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_COLUMNS = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROWS    = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_SURVIVE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_BIRTH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_BORDER  = 3'd4;

    // register reset values
    localparam logic [COUNT_W-1:0] RST_COLUMNS = 7'd64;
    localparam logic [COUNT_W-1:0] RST_ROWS    = 7'd64;
    localparam logic [MASK_W-1:0]  RST_SURVIVE = 9'd12;
    localparam logic [MASK_W-1:0]  RST_BIRTH   = 9'd8;

    // border modes, the unused code acts as a dead border
    localparam logic [MODE_W-1:0] MODE_WRAP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DEAD = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LIVE = 2'd2;

    typedef enum logic [1:0] {
        ACT_WRITE   = 2'd0,
        ACT_READ    = 2'd1,
        ACT_FILL    = 2'd2,
        ACT_ADVANCE = 2'd3
    } action_t;

    typedef struct packed {
        logic [MASK_W-1:0] survive_mask;
        logic [MASK_W-1:0] birth_mask;
        logic [MODE_W-1:0] border_mode;
    } rule_cfg_t;

endpackage

`default_nettype wire

[hdl/llag_cfg.sv]
// configuration registers and clamped grid size
`default_nettype none

module llag_cfg #(
    parameter int MAX_COLUMNS = llag_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = llag_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [llag_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  wire logic [llag_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    output      logic [$clog2(MAX_COLUMNS+1)-1:0]      cols_eff,
    output      logic [$clog2(MAX_ROWS+1)-1:0]         rows_eff,
    output      llag_pkg::rule_cfg_t                   rule
);

    localparam int COL_CW = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int CCMP_W = (COL_CW > llag_pkg::COUNT_W) ? COL_CW : llag_pkg::COUNT_W;
    localparam int RCMP_W = (ROW_CW > llag_pkg::COUNT_W) ? ROW_CW : llag_pkg::COUNT_W;

    logic [llag_pkg::COUNT_W-1:0] columns_reg;
    logic [llag_pkg::COUNT_W-1:0] rows_reg;
    llag_pkg::rule_cfg_t          rule_reg;
    logic [CCMP_W-1:0]            cols_ext;
    logic [RCMP_W-1:0]            rows_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg           <= llag_pkg::RST_COLUMNS;
            rows_reg              <= llag_pkg::RST_ROWS;
            rule_reg.survive_mask <= llag_pkg::RST_SURVIVE;
            rule_reg.birth_mask   <= llag_pkg::RST_BIRTH;
            rule_reg.border_mode  <= llag_pkg::MODE_WRAP;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                llag_pkg::REG_COLUMNS: columns_reg <= llag_pkg::COUNT_W'(cfg_wdata);
                llag_pkg::REG_ROWS:    rows_reg    <= llag_pkg::COUNT_W'(cfg_wdata);
                llag_pkg::REG_SURVIVE: rule_reg.survive_mask <= cfg_wdata;
                llag_pkg::REG_BIRTH:   rule_reg.birth_mask   <= cfg_wdata;
                llag_pkg::REG_BORDER:
                    rule_reg.border_mode <= llag_pkg::MODE_W'(cfg_wdata);
                default: ;
            endcase
        end
    end

    // clamp sizes to 1..max
    always_comb
    begin
        cols_ext = CCMP_W'(columns_reg);
        rows_ext = RCMP_W'(rows_reg);
        if (cols_ext == '0)
            cols_eff = COL_CW'(1);
        else if (cols_ext > CCMP_W'(MAX_COLUMNS))
            cols_eff = COL_CW'(MAX_COLUMNS);
        else
            cols_eff = COL_CW'(cols_ext);
        if (rows_ext == '0)
            rows_eff = ROW_CW'(1);
        else if (rows_ext > RCMP_W'(MAX_ROWS))
            rows_eff = ROW_CW'(MAX_ROWS);
        else
            rows_eff = ROW_CW'(rows_ext);
    end

    assign rule = rule_reg;

endmodule

`default_nettype wire

[hdl/llag_rule.sv]
// shared cell unit: gathers eight neighbours, counts them, applies the rule
`default_nettype none

module llag_rule #(
    parameter int MAX_COLUMNS = llag_pkg::DEF_MAX_COLUMNS
) (
    input  wire logic [MAX_COLUMNS-1:0]                          row_above,
    input  wire logic [MAX_COLUMNS-1:0]                          row_cur,
    input  wire logic [MAX_COLUMNS-1:0]                          row_below,
    input  wire logic [((MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1)-1:0] x,
    input  wire logic [$clog2(MAX_COLUMNS+1)-1:0]                cols_eff,
    input  wire llag_pkg::rule_cfg_t                             rule,
    output      logic                                            next_cell
);

    localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_CW = $clog2(MAX_COLUMNS + 1);

    logic                        wrap;
    logic                        border;
    logic [COL_CW-1:0]           cols_m1;
    logic                        x_first;
    logic                        x_last;
    logic [COL_AW-1:0]           xm;
    logic [COL_AW-1:0]           xp;
    logic                        left_off;
    logic                        right_off;
    logic                        a_l, a_c, a_r, c_l, c_r, b_l, b_c, b_r;
    logic                        self;
    logic [3:0]                  count;
    logic [llag_pkg::MASK_W-1:0] mask;

    always_comb
    begin
        wrap      = (rule.border_mode == llag_pkg::MODE_WRAP);
        border    = (rule.border_mode == llag_pkg::MODE_LIVE);
        cols_m1   = cols_eff - COL_CW'(1);
        x_first   = (x == '0);
        x_last    = (COL_CW'(x) == cols_m1);
        xm        = x_first ? cols_m1[COL_AW-1:0] : x - COL_AW'(1);
        xp        = x_last ? '0 : x + COL_AW'(1);
        left_off  = x_first && !wrap;
        right_off = x_last && !wrap;

        // rows above and below are already border rows when off the grid
        a_l  = left_off  ? border : row_above[xm];
        a_c  = row_above[x];
        a_r  = right_off ? border : row_above[xp];
        c_l  = left_off  ? border : row_cur[xm];
        c_r  = right_off ? border : row_cur[xp];
        b_l  = left_off  ? border : row_below[xm];
        b_c  = row_below[x];
        b_r  = right_off ? border : row_below[xp];
        self = row_cur[x];

        count = 4'(a_l) + 4'(a_c) + 4'(a_r) + 4'(c_l)
              + 4'(c_r) + 4'(b_l) + 4'(b_c) + 4'(b_r);
        mask      = self ? rule.survive_mask : rule.birth_mask;
        next_cell = mask[count];
    end

endmodule

`default_nettype wire

[hdl/life_like_automaton_grid.sv]
// top level: row store, item sequencer and result register of the automaton grid
// write or read of one cell: access, then response; off the grid, the response alone
// fill: one store row written per cycle over all MAX_ROWS rows, then the response
// advance: one row at a time, one cell
//   per cycle through the shared neighbour-count unit plus row fetch and write-back
// one request at a time; a new request is taken while the previous result still waits
// reset: async, active low; a clearing pass then zeroes every store row
`default_nettype none

module life_like_automaton_grid #(
    parameter int MAX_COLUMNS = llag_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = llag_pkg::DEF_MAX_ROWS
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    // request stream
    input  wire logic                                 s_axis_tvalid,
    output      logic                                 s_axis_tready,
    // [1:0] action, [7:2] x_coord, [13:8] y_coord, [14] cell_value, [15] zero
    input  wire logic [llag_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // result stream
    output      logic                                 m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [0] read_value, [7:1] zero
    output      logic [llag_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // configuration writes
    input  wire logic                                 cfg_wr_en,
    input  wire logic [llag_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  wire logic [llag_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    localparam int COL_AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int COL_CW = $clog2(MAX_COLUMNS + 1);
    localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int ROW_CW = $clog2(MAX_ROWS + 1);
    localparam int XCMP_W = (COL_CW > llag_pkg::COORD_W) ? COL_CW : llag_pkg::COORD_W;
    localparam int YCMP_W = (ROW_CW > llag_pkg::COORD_W) ? ROW_CW : llag_pkg::COORD_W;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_READ,
        S_FILL,
        S_ADV_ROW0,
        S_ADV_LAST,
        S_ADV_ABOVE,
        S_ADV_BELOW,
        S_ADV_GET,
        S_ADV_CELL,
        S_ADV_STORE,
        S_RESP
    } state_t;

    // configuration
    logic [COL_CW-1:0]   cols_eff;
    logic [ROW_CW-1:0]   rows_eff;
    llag_pkg::rule_cfg_t rule;

    llag_cfg #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cols_eff  (cols_eff),
        .rows_eff  (rows_eff),
        .rule      (rule)
    );

    // control registers
    state_t            state_reg,     state_next;
    logic [ROW_AW-1:0] y_cnt_reg,     y_cnt_next;
    logic [COL_AW-1:0] x_cnt_reg,     x_cnt_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_read_reg,  out_read_next;

    // request and row registers
    logic [COL_AW-1:0]      x_reg,      x_next;
    logic [ROW_AW-1:0]      y_reg,      y_next;
    logic                   val_reg,    val_next;
    logic                   result_reg, result_next;
    logic [MAX_COLUMNS-1:0] above_reg,  above_next;
    logic [MAX_COLUMNS-1:0] cur_reg,    cur_next;
    logic [MAX_COLUMNS-1:0] below_reg,  below_next;
    logic [MAX_COLUMNS-1:0] first_reg,  first_next;
    logic [MAX_COLUMNS-1:0] new_row_reg, new_row_next;

    // row store: one word per row, one bit per column
    logic [MAX_COLUMNS-1:0] grid_mem [MAX_ROWS];
    logic [MAX_COLUMNS-1:0] rd_data_reg;
    logic [ROW_AW-1:0]      rd_addr;
    logic                   mem_we;
    logic [ROW_AW-1:0]      wr_addr;
    logic [MAX_COLUMNS-1:0] wr_data;

    // request fields
    llag_pkg::action_t           in_action;
    logic [llag_pkg::COORD_W-1:0] in_x;
    logic [llag_pkg::COORD_W-1:0] in_y;
    logic                        in_val;
    logic                        in_inside;
    logic                        accept;

    // helpers
    logic                   wrap;
    logic [MAX_COLUMNS-1:0] border_row;
    logic [COL_CW-1:0]      cols_m1;
    logic [ROW_CW-1:0]      rows_m1;
    logic                   rule_next;
    logic [MAX_COLUMNS-1:0] row_mod;

    assign in_action = llag_pkg::action_t'(s_axis_tdata[1:0]);
    assign in_x      = s_axis_tdata[7:2];
    assign in_y      = s_axis_tdata[13:8];
    assign in_val    = s_axis_tdata[14];
    assign in_inside = (XCMP_W'(in_x) < XCMP_W'(cols_eff))
                    && (YCMP_W'(in_y) < YCMP_W'(rows_eff));

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = llag_pkg::OUT_TDATA_W'(out_read_reg);

    // unused border code reads as dead
    assign wrap       = (rule.border_mode == llag_pkg::MODE_WRAP);
    assign border_row = {MAX_COLUMNS{rule.border_mode == llag_pkg::MODE_LIVE}};
    assign cols_m1    = cols_eff - COL_CW'(1);
    assign rows_m1    = rows_eff - ROW_CW'(1);

    // shared cell unit, one cell of the current row per cycle
    llag_rule #(
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_rule (
        .row_above (above_reg),
        .row_cur   (cur_reg),
        .row_below (below_reg),
        .x         (x_cnt_reg),
        .cols_eff  (cols_eff),
        .rule      (rule),
        .next_cell (rule_next)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        y_cnt_next     = y_cnt_reg;
        x_cnt_next     = x_cnt_reg;
        out_valid_next = out_valid_reg;
        out_read_next  = out_read_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        val_next       = val_reg;
        result_next    = result_reg;
        above_next     = above_reg;
        cur_next       = cur_reg;
        below_next     = below_reg;
        first_next     = first_reg;
        new_row_next   = new_row_reg;
        rd_addr        = y_cnt_reg;
        mem_we         = 1'b0;
        wr_addr        = y_cnt_reg;
        wr_data        = new_row_reg;
        row_mod        = rd_data_reg;

        // result taken downstream
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                // zero every store row after reset
                mem_we  = 1'b1;
                wr_data = '0;
                if (y_cnt_reg == ROW_AW'(MAX_ROWS - 1))
                begin
                    y_cnt_next = '0;
                    state_next = S_IDLE;
                end
                else
                    y_cnt_next = y_cnt_reg + ROW_AW'(1);
            end
            S_IDLE:
            begin
                // row of the addressed cell is fetched while the request is taken
                rd_addr = ROW_AW'(in_y);
                if (accept)
                begin
                    x_next      = COL_AW'(in_x);
                    y_next      = ROW_AW'(in_y);
                    val_next    = in_val;
                    result_next = 1'b0;
                    case (in_action)
                        llag_pkg::ACT_WRITE:   state_next = in_inside ? S_WRITE : S_RESP;
                        llag_pkg::ACT_READ:    state_next = in_inside ? S_READ : S_RESP;
                        llag_pkg::ACT_FILL:
                        begin
                            y_cnt_next = '0;
                            state_next = S_FILL;
                        end
                        llag_pkg::ACT_ADVANCE: state_next = S_ADV_ROW0;
                        default:               state_next = S_RESP;
                    endcase
                end
            end
            S_WRITE:
            begin
                // read-modify-write of one row
                row_mod[x_reg] = val_reg;
                mem_we         = 1'b1;
                wr_addr        = y_reg;
                wr_data        = row_mod;
                state_next     = S_RESP;
            end
            S_READ:
            begin
                result_next = rd_data_reg[x_reg];
                state_next  = S_RESP;
            end
            S_FILL:
            begin
                // fill covers the whole store, active or not
                mem_we  = 1'b1;
                wr_data = {MAX_COLUMNS{val_reg}};
                if (y_cnt_reg == ROW_AW'(MAX_ROWS - 1))
                begin
                    y_cnt_next = '0;
                    state_next = S_RESP;
                end
                else
                    y_cnt_next = y_cnt_reg + ROW_AW'(1);
            end
            S_ADV_ROW0:
            begin
                rd_addr    = '0;
                state_next = S_ADV_LAST;
            end
            S_ADV_LAST:
            begin
                // keep old row 0: the last row wraps onto it after it is rewritten
                cur_next   = rd_data_reg;
                first_next = rd_data_reg;
                rd_addr    = rows_m1[ROW_AW-1:0];
                state_next = S_ADV_ABOVE;
            end
            S_ADV_ABOVE:
            begin
                above_next = wrap ? rd_data_reg : border_row;
                y_cnt_next = '0;
                state_next = S_ADV_BELOW;
            end
            S_ADV_BELOW:
            begin
                if (ROW_CW'(y_cnt_reg) < rows_m1)
                begin
                    rd_addr    = y_cnt_reg + ROW_AW'(1);
                    state_next = S_ADV_GET;
                end
                else
                begin
                    below_next   = wrap ? first_reg : border_row;
                    new_row_next = cur_reg;
                    x_cnt_next   = '0;
                    state_next   = S_ADV_CELL;
                end
            end
            S_ADV_GET:
            begin
                below_next   = rd_data_reg;
                new_row_next = cur_reg;
                x_cnt_next   = '0;
                state_next   = S_ADV_CELL;
            end
            S_ADV_CELL:
            begin
                // columns past the active width keep their old bits
                new_row_next[x_cnt_reg] = rule_next;
                if (COL_CW'(x_cnt_reg) == cols_m1)
                    state_next = S_ADV_STORE;
                else
                    x_cnt_next = x_cnt_reg + COL_AW'(1);
            end
            S_ADV_STORE:
            begin
                // write back in place; the old row moves up the window
                mem_we     = 1'b1;
                wr_addr    = y_cnt_reg;
                wr_data    = new_row_reg;
                above_next = cur_reg;
                cur_next   = below_reg;
                if (ROW_CW'(y_cnt_reg) == rows_m1)
                begin
                    y_cnt_next = '0;
                    state_next = S_RESP;
                end
                else
                begin
                    y_cnt_next = y_cnt_reg + ROW_AW'(1);
                    state_next = S_ADV_BELOW;
                end
            end
            S_RESP:
            begin
                // hand the result over once the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_read_next  = result_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            y_cnt_reg     <= '0;
            x_cnt_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_read_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            y_cnt_reg     <= y_cnt_next;
            x_cnt_reg     <= x_cnt_next;
            out_valid_reg <= out_valid_next;
            out_read_reg  <= out_read_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        val_reg     <= val_next;
        result_reg  <= result_next;
        above_reg   <= above_next;
        cur_reg     <= cur_next;
        below_reg   <= below_next;
        first_reg   <= first_next;
        new_row_reg <= new_row_next;
    end

    // row store, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[wr_addr] <= wr_data;
        rd_data_reg <= grid_mem[rd_addr];
    end

`ifndef SYNTHESIS
    // one request at a time: ready drops right after a request is taken
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("request taken while another is in work");

    // a result appears only out of the response step
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_RESP))
        else $error("result raised outside the response step");

    // the cell walk stays inside the active width
    a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV_CELL) |-> (COL_CW'(x_cnt_reg) < cols_eff))
        else $error("cell walk beyond active columns");

    // write-back stays inside the active height
    a_row_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV_STORE) |-> (ROW_CW'(y_cnt_reg) < rows_eff))
        else $error("row write-back beyond active rows");
`endif

endmodule

`default_nettype wire

[test/llag_checker.sv]
// checker for the life-like automaton grid: shadow grid, pending reads and result compare
module llag_checker
    import llag_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    input  logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    input  logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output int                     outstanding,
    output int                     failures,
    output int                     results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow registers
    logic [COUNT_W-1:0] columns_reg;
    logic [COUNT_W-1:0] rows_reg;
    logic [MASK_W-1:0]  survive_reg;
    logic [MASK_W-1:0]  birth_reg;
    logic [MODE_W-1:0]  border_reg;

    // shadow of the current generation, indexed [row][column]
    logic [MAX_COLUMNS-1:0] live_cells [MAX_ROWS];

    logic pending_reads [$];
    int   mismatch_count;
    int   result_count;

    task automatic report_mismatch(input string what, input logic [OUT_TDATA_W-1:0] want,
                                   input logic [OUT_TDATA_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %0h, got %0h", $time, what, want, got);
        mismatch_count++;
    endtask

    function automatic int clamp_size(input logic [COUNT_W-1:0] req, input int limit);
        if (req == 0)
            return 1;
        if (int'(req) > limit)
            return limit;
        return int'(req);
    endfunction

    // x and y may lie one step beyond the active grid
    function automatic logic neighbour_alive(input int x, input int y, input int cols,
                                             input int rows);
        if (border_reg == MODE_WRAP)
        begin
            if (x < 0) x += cols;
            if (x >= cols) x -= cols;
            if (y < 0) y += rows;
            if (y >= rows) y -= rows;
        end
        else if (x < 0 || y < 0 || x >= cols || y >= rows)
            return border_reg == MODE_LIVE;
        return live_cells[y][x];
    endfunction

    function automatic void step_shadow_grid();
        logic [MAX_COLUMNS-1:0] upcoming [MAX_ROWS];
        int cols;
        int rows;
        int x;
        int y;
        int dx;
        int dy;
        int total;
        cols = clamp_size(columns_reg, MAX_COLUMNS);
        rows = clamp_size(rows_reg, MAX_ROWS);
        upcoming = live_cells;
        for (y = 0; y < rows; y++)
            for (x = 0; x < cols; x++)
            begin
                total = 0;
                for (dy = -1; dy <= 1; dy++)
                    for (dx = -1; dx <= 1; dx++)
                        if (dx != 0 || dy != 0)
                            total += neighbour_alive(x + dx, y + dy, cols, rows);
                upcoming[y][x] = live_cells[y][x] ? survive_reg[total] : birth_reg[total];
            end
        live_cells = upcoming;
    endfunction

    // applies one request to the shadow grid and returns the value it reads back
    function automatic logic apply_request(input logic [IN_TDATA_W-1:0] word);
        action_t act;
        int      x;
        int      y;
        int      r;
        logic    fill_value;
        logic    in_grid;
        act        = action_t'(word[1:0]);
        x          = word[2 +: COORD_W];
        y          = word[2 + COORD_W +: COORD_W];
        fill_value = word[2 + 2 * COORD_W];
        in_grid    = x < clamp_size(columns_reg, MAX_COLUMNS)
                  && y < clamp_size(rows_reg, MAX_ROWS);
        case (act)
            ACT_WRITE:
                if (in_grid)
                    live_cells[y][x] = fill_value;
            ACT_READ:
                if (in_grid)
                    return live_cells[y][x];
            ACT_FILL:
                for (r = 0; r < MAX_ROWS; r++)
                    live_cells[r] = {MAX_COLUMNS{fill_value}};
            default:
                step_shadow_grid();
        endcase
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg = RST_COLUMNS;
            rows_reg    = RST_ROWS;
            survive_reg = RST_SURVIVE;
            birth_reg   = RST_BIRTH;
            border_reg  = MODE_WRAP;
            foreach (live_cells[r])
                live_cells[r] = '0;
            pending_reads.delete();
        end
        else
        begin
            // results first: a result never belongs to a request taken at the same edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                result_count++;
                if (pending_reads.size() == 0)
                    report_mismatch("result with no request pending", '0, m_axis_tdata);
                else
                begin
                    if (m_axis_tdata[0] !== pending_reads[0])
                        report_mismatch("read_value", OUT_TDATA_W'(pending_reads[0]),
                                        OUT_TDATA_W'(m_axis_tdata[0]));
                    if (m_axis_tdata[OUT_TDATA_W-1:1] !== '0)
                        report_mismatch("result padding", '0, m_axis_tdata);
                    void'(pending_reads.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                pending_reads.push_back(apply_request(s_axis_tdata));
            if (cfg_wr_en)
                case (cfg_addr)
                    REG_COLUMNS: columns_reg = cfg_wdata[COUNT_W-1:0];
                    REG_ROWS:    rows_reg    = cfg_wdata[COUNT_W-1:0];
                    REG_SURVIVE: survive_reg = cfg_wdata[MASK_W-1:0];
                    REG_BIRTH:   birth_reg   = cfg_wdata[MASK_W-1:0];
                    REG_BORDER:  border_reg  = cfg_wdata[MODE_W-1:0];
                    default: ;
                endcase
        end
        outstanding  <= pending_reads.size();
        failures     <= mismatch_count;
        results_seen <= result_count;
    end

endmodule

[test/tb_life_like_automaton_grid.sv]
// testbench top for the life-like automaton grid: clock, reset, stimulus, watchdog, verdict
module tb_life_like_automaton_grid
    import llag_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    // longest quiet stretch: a 64 by 64 advance plus the long result hold-off
    // and a long source gap, taken several times over
    localparam int QUIET_LIMIT   = 25000;
    localparam int LONG_HOLD     = 300;
    localparam int SETTLE_CYCLES = 16;
    localparam int COORD_MAX     = 2 ** COORD_W - 1;

    // indexes past the last register, the block must ignore writes to them
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;
    // unused border code, behaves as a dead border
    localparam logic [MODE_W-1:0]     MODE_SPARE      = 2'd3;
    // highlife rule: survive on 2 or 3, born on 3 or 6
    localparam logic [MASK_W-1:0]     HIGHLIFE_BIRTH  = 9'h048;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   cfg_wr_en;
    logic [CFG_ADDR_W-1:0]  cfg_addr;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int outstanding;
    int failures;
    int results_seen;

    // idling controls, switched per phase
    bit src_gaps_on;
    bit sink_gaps_on;
    bit long_hold_req;
    int long_holds;

    // active grid as last programmed, used to aim coordinates
    int grid_w = DEF_MAX_COLUMNS;
    int grid_h = DEF_MAX_ROWS;
    int settings_used = 1;
    int sent_by_action [4];

    always #(CLK_PERIOD / 2) clk = ~clk;

    life_like_automaton_grid u_top (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .cfg_wr_en,
        .cfg_addr,
        .cfg_wdata
    );

    llag_checker u_checker (
        .clk,
        .rst_n,
        .s_axis_tvalid,
        .s_axis_tready,
        .s_axis_tdata,
        .m_axis_tvalid,
        .m_axis_tready,
        .m_axis_tdata,
        .cfg_wr_en,
        .cfg_addr,
        .cfg_wdata,
        .outstanding,
        .failures,
        .results_seen
    );

    // mostly no gap, often a short one, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 48);
    endfunction

    // offer one request and hold it until the block takes it
    task automatic send_request(input action_t act, input int x, input int y,
                                input logic fill_value);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, fill_value, y[COORD_W-1:0], x[COORD_W-1:0], act};
        do
            @(posedge clk);
        while (!s_axis_tready);
        sent_by_action[int'(act)]++;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // stop offering and wait until every result has come back
    task automatic finish_outstanding();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // reprogram all registers while the block is idle; upper data bits are don't-care
    task automatic apply_settings(input logic [COUNT_W-1:0] cols_w,
                                  input logic [COUNT_W-1:0] rows_w,
                                  input logic [MASK_W-1:0]  survive,
                                  input logic [MASK_W-1:0]  birth,
                                  input logic [MODE_W-1:0]  mode);
        logic [CFG_DATA_W-1:0] reg_values [REG_BORDER + 1];
        int idx;
        finish_outstanding();
        reg_values[REG_COLUMNS] = {2'($urandom), cols_w};
        reg_values[REG_ROWS]    = {2'($urandom), rows_w};
        reg_values[REG_SURVIVE] = survive;
        reg_values[REG_BIRTH]   = birth;
        reg_values[REG_BORDER]  = {7'($urandom), mode};
        for (idx = REG_COLUMNS; idx <= REG_BORDER; idx++)
        begin
            cfg_wr_en <= 1'b1;
            cfg_addr  <= CFG_ADDR_W'(idx);
            cfg_wdata <= reg_values[idx];
            @(posedge clk);
        end
        // a write to a spare index must leave every register alone
        cfg_addr  <= CFG_ADDR_W'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST));
        cfg_wdata <= CFG_DATA_W'($urandom);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        grid_w = (cols_w == 0) ? 1 : (cols_w > DEF_MAX_COLUMNS) ? DEF_MAX_COLUMNS : cols_w;
        grid_h = (rows_w == 0) ? 1 : (rows_w > DEF_MAX_ROWS) ? DEF_MAX_ROWS : rows_w;
        settings_used++;
    endtask

    // one random request; coordinates mostly land on the active grid
    task automatic random_request(input int advance_weight);
        action_t act;
        int      roll;
        int      x;
        int      y;
        roll = $urandom_range(0, 99);
        if (roll < advance_weight)
            act = ACT_ADVANCE;
        else if (roll < advance_weight + 5)
            act = ACT_FILL;
        else if (roll < 55)
            act = ACT_WRITE;
        else
            act = ACT_READ;
        if ($urandom_range(0, 4) == 0)
        begin
            x = $urandom_range(0, COORD_MAX);
            y = $urandom_range(0, COORD_MAX);
        end
        else
        begin
            x = $urandom_range(0, grid_w - 1);
            y = $urandom_range(0, grid_h - 1);
        end
        // writes lean toward live cells so generations have something to do
        send_request(act, x, y, $urandom_range(0, 2) != 0);
    endtask

    // one random phase under fresh settings; hold_at >= 0 starts a long result hold-off
    task automatic run_phase(input logic [COUNT_W-1:0] cols_w,
                             input logic [COUNT_W-1:0] rows_w,
                             input logic [MASK_W-1:0]  survive,
                             input logic [MASK_W-1:0]  birth,
                             input logic [MODE_W-1:0]  mode,
                             input int count, input int advance_weight,
                             input int hold_at);
        int n;
        apply_settings(cols_w, rows_w, survive, birth, mode);
        if (hold_at >= 0)
        begin
            // pressure: no gaps, so requests pile up behind the held result
            src_gaps_on  = 1'b0;
            sink_gaps_on = 1'b0;
        end
        else
        begin
            src_gaps_on  = $urandom_range(0, 3) != 0;
            sink_gaps_on = $urandom_range(0, 3) != 0;
        end
        for (n = 0; n < count; n++)
        begin
            if (n == hold_at)
                long_hold_req <= 1'b1;
            random_request(advance_weight);
            if ($urandom_range(0, 19) == 0)
                finish_outstanding();
        end
    endtask

    // result side: random hold-offs, plus a long one on request
    initial
    begin : result_sink
        int hold;
        hold = 0;
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req <= 1'b0;
                hold = LONG_HOLD;
                long_holds++;
            end
            else if (hold == 0 && sink_gaps_on && $urandom_range(0, 7) == 0)
                hold = pick_gap();
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                hold--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ends the run if neither stream moves for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("life_like_automaton_grid regression: fail");
        $finish;
    end

    initial
    begin : stimulus
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = REG_COLUMNS;
        cfg_wdata     = '0;
        src_gaps_on   = 1'b1;
        sink_gaps_on  = 1'b1;
        long_hold_req = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: full 64 by 64 grid, wrap, survive on 2 or 3, born on 3
        send_request(ACT_READ, 0, 0, 1'b0);
        send_request(ACT_WRITE, COORD_MAX, COORD_MAX, 1'b1);
        send_request(ACT_READ, COORD_MAX, COORD_MAX, 1'b0);
        send_request(ACT_WRITE, 0, 0, 1'b1);
        send_request(ACT_WRITE, COORD_MAX, 0, 1'b1);
        send_request(ACT_WRITE, 0, COORD_MAX, 1'b1);
        // the four corners touch across the wrap and form a stable block
        send_request(ACT_ADVANCE, 0, 0, 1'b0);
        send_request(ACT_READ, 0, COORD_MAX, 1'b0);
        // a full grid dies of crowding in one generation
        send_request(ACT_FILL, 0, 0, 1'b1);
        send_request(ACT_ADVANCE, COORD_MAX, COORD_MAX, 1'b1);
        send_request(ACT_READ, 32, 17, 1'b0);

        // small grid with everything dying: cells outside the grid must take the fill, stay
        // untouched by writes and by the generation, and read as zero while outside
        apply_settings(7'd5, 7'd4, '0, '0, MODE_DEAD);
        send_request(ACT_FILL, 0, 0, 1'b1);
        send_request(ACT_WRITE, 10, 2, 1'b0);
        send_request(ACT_READ, 10, 2, 1'b0);
        send_request(ACT_ADVANCE, 0, 0, 1'b0);

        // oversize width clamps to the full store; resizing must not move cells
        apply_settings(7'd127, 7'd64, '1, '1, MODE_SPARE);
        send_request(ACT_READ, 10, 2, 1'b0);
        send_request(ACT_READ, 4, 3, 1'b0);

        // zero sizes clamp to a single cell that wraps onto itself eight times
        apply_settings(7'd0, 7'd0, 9'h100, '0, MODE_WRAP);
        send_request(ACT_WRITE, 0, 0, 1'b1);
        send_request(ACT_ADVANCE, 0, 0, 1'b0);
        send_request(ACT_READ, 0, 0, 1'b0);

        // one-wide column under a living border: middle cell sees six live border cells
        apply_settings(7'd1, 7'd3, '0, 9'h040, MODE_LIVE);
        send_request(ACT_FILL, 0, 0, 1'b0);
        send_request(ACT_ADVANCE, 0, 0, 1'b0);
        send_request(ACT_READ, 0, 1, 1'b0);

        // random phases, small grids for most of the generations
        run_phase(7'd8, 7'd8, RST_SURVIVE, RST_BIRTH, MODE_WRAP, 10, 15, -1);
        run_phase(7'd1, 7'd1, 9'($urandom), 9'($urandom), MODE_WRAP, 8, 25, -1);
        run_phase(7'd1, 7'd64, 9'($urandom), 9'($urandom), MODE_WRAP, 10, 20, -1);
        run_phase(7'd64, 7'd1, 9'($urandom), 9'($urandom), MODE_WRAP, 10, 20, -1);
        run_phase(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)), 9'($urandom),
                  9'($urandom), MODE_DEAD, 16, 15, -1);
        run_phase(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)), 9'($urandom),
                  9'($urandom), MODE_LIVE, 16, 15, -1);
        run_phase(7'($urandom_range(2, 12)), 7'($urandom_range(2, 12)), 9'($urandom),
                  9'($urandom), MODE_SPARE, 10, 15, -1);
        // back-to-back requests while the result side holds off for a long stretch
        run_phase(7'd6, 7'd6, RST_SURVIVE, HIGHLIFE_BIRTH, MODE_WRAP, 24, 10, 4);
        // a few requests on the full store, rarely advancing since each pass is long
        run_phase(7'd64, 7'd64, 9'($urandom), 9'($urandom), MODE_WRAP, 14, 8, -1);

        finish_outstanding();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d writes, %0d reads, %0d fills, %0d advances",
                 results_seen, sent_by_action[ACT_WRITE], sent_by_action[ACT_READ],
                 sent_by_action[ACT_FILL], sent_by_action[ACT_ADVANCE]);
        $display("%0d register settings from 1x1 to 64x64, all border codes, %0d long stalls",
                 settings_used, long_holds);
        if (failures == 0 && outstanding == 0)
            $display("life_like_automaton_grid regression: pass");
        else
            $display("life_like_automaton_grid regression: fail");
        $finish;
    end

endmodule
